### design/dsl_pkg.sv
// ----------------------------------------------------------------------------
// dsl_pkg - shared types and constants of the disk image sector locator
// Operation and status codes, header byte positions, signature strings and
// the payload types that the item and result channels carry.
// ----------------------------------------------------------------------------
package dsl_pkg;

  localparam int HEADER_BYTES = 256;

  localparam logic [1:0] OP_LOAD_DISK    = 2'd0;
  localparam logic [1:0] OP_LOAD_TRACK   = 2'd1;
  localparam logic [1:0] OP_FIND_TRACK   = 2'd2;
  localparam logic [1:0] OP_FIND_SECTOR  = 2'd3;

  localparam logic [1:0] STAT_OK           = 2'd0;
  localparam logic [1:0] STAT_SEEK_FAIL    = 2'd1;
  localparam logic [1:0] STAT_NO_SECTOR    = 2'd2;
  localparam logic [1:0] STAT_LEN_MISMATCH = 2'd3;

  localparam logic [7:0] HDR_CYLS        = 8'h30;
  localparam logic [7:0] HDR_SIZES       = 8'h34;
  localparam logic [7:0] TRK_SIZE_CODE   = 8'h14;
  localparam logic [7:0] TRK_ENTRIES     = 8'h18;

  localparam logic [9:0]  SIZE_TABLE_ENTRIES = 10'd204;
  localparam logic [4:0]  MAX_SECTOR_ENTRIES = 5'd29;
  localparam logic [3:0]  MAX_SIZE_CODE      = 4'd8;
  localparam logic [15:0] SECTOR_BASE_LEN    = 16'h0080;
  localparam logic [31:0] HEADER_SPAN        = 32'd256;

  localparam logic [7:0] EXT_TAG [8] = '{
    8'h45, 8'h58, 8'h54, 8'h45, 8'h4e, 8'h44, 8'h45, 8'h44
  };
  localparam logic [7:0] TRK_TAG [10] = '{
    8'h54, 8'h72, 8'h61, 8'h63, 8'h6b, 8'h2d, 8'h49, 8'h6e, 8'h66, 8'h6f
  };

  localparam logic [1:0] TAG_DH  = 2'd0;
  localparam logic [1:0] TAG_SUM = 2'd1;
  localparam logic [1:0] TAG_TH  = 2'd2;
  localparam logic [1:0] TAG_ENT = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  byte_index;
    logic [7:0]  byte_value;
    logic [7:0]  cylinder;
    logic [7:0]  head;
    logic [7:0]  sector;
    logic [7:0]  cyl_expected;
    logic [7:0]  head_expected;
    logic [15:0] request_len;
    logic [15:0] buffer_len;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] image_offset;
    logic [15:0] transfer_len;
  } result_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] kind;
    logic [3:0] step;
  } tag_t;

endpackage

### design/dsl_if.sv
// ----------------------------------------------------------------------------
// dsl_if - valid/ready channels of the disk image sector locator
// One interface for the item channel and one for the result channel.
// ----------------------------------------------------------------------------
interface dsl_item_if;
  logic           valid;
  logic           ready;
  dsl_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dsl_result_if;
  logic             valid;
  logic             ready;
  dsl_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/disk_image_sector_locator.sv
// ----------------------------------------------------------------------------
// disk_image_sector_locator - track and sector lookup in a disk image header
// Holds the disk header and the track header in two 256x8 memories and walks
// them one byte per cycle to locate tracks and sectors.
// ----------------------------------------------------------------------------
// Usage: items arrive on the item channel, one result per item leaves on the
// result channel; a transfer takes place when valid and ready are both high.
// Load items write one header byte; their result then passes through the
// output register. Find track reads 12 disk header bytes through the memory
// read port, one per cycle; in an extended image it also reads one size
// table byte for each track before the one looked up (up to 203). Find
// sector also checks the 12 track header bytes and then scans the sector
// entries (up to 29), reading the ID and length of each and the cylinder
// and head of the match. The worst case is set by the single read port of
// each header memory. One item is in work at a time; the next item is taken
// as soon as the previous result sits in the output register, even while
// the receiver stalls it. Reset clears the control state, the output valid
// and the current track offset; header memory contents stay undefined until
// loaded. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module disk_image_sector_locator (
  input  logic              clk,
  input  logic              rst,
  dsl_item_if.sink          item,
  dsl_result_if.source      result
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DSCAN = 4'd1;
  localparam logic [3:0] S_DCHK  = 4'd2;
  localparam logic [3:0] S_SUM   = 4'd3;
  localparam logic [3:0] S_TRKOK = 4'd4;
  localparam logic [3:0] S_TSCAN = 4'd5;
  localparam logic [3:0] S_TCHK  = 4'd6;
  localparam logic [3:0] S_ENT   = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;
  localparam logic [3:0] S_RES   = 4'd9;

  localparam logic [2:0] SUB_ID    = 3'd0;
  localparam logic [2:0] SUB_LLO   = 3'd1;
  localparam logic [2:0] SUB_LHI   = 3'd2;
  localparam logic [2:0] SUB_CYL   = 3'd3;
  localparam logic [2:0] SUB_HD    = 3'd4;
  localparam logic [2:0] SUB_DRAIN = 3'd5;

  localparam logic [3:0] SCAN_END = 4'd12;
  localparam logic [3:0] EXT_LEN  = 4'd8;
  localparam logic [3:0] SIG_LEN  = 4'd10;

  logic [7:0] dh_mem [dsl_pkg::HEADER_BYTES];
  logic [7:0] th_mem [dsl_pkg::HEADER_BYTES];

  logic [3:0]       state;
  logic [3:0]       step;
  logic [7:0]       cnt;
  logic [4:0]       n;
  logic [2:0]       sub;
  dsl_pkg::tag_t    tag;
  dsl_pkg::tag_t    iss;
  logic [7:0]       dh_raddr;
  logic [7:0]       th_raddr;
  logic [7:0]       dh_rdata;
  logic [7:0]       th_rdata;
  logic             o_vld;
  dsl_pkg::result_t o_data;
  dsl_pkg::result_t res;
  dsl_pkg::result_t fin_res;
  logic [31:0]      cur_off;

  dsl_pkg::item_t   req;
  logic             ext_ok;
  logic             sig_ok;
  logic [7:0]       max_cyl;
  logic [7:0]       heads;
  logic [15:0]      tlen;
  logic [7:0]       trk;
  logic [31:0]      acc;
  logic [7:0]       code_raw;
  logic [7:0]       count_raw;
  logic [3:0]       code_lim;
  logic [4:0]       cnt_lim;
  logic             id_match;
  logic             cyl_ok;
  logic             hd_ok;
  logic [7:0]       len_lo;
  logic [15:0]      seclen;
  logic [20:0]      offs;

  logic             accept;
  logic             fire_res;
  logic [9:0]       trk_calc;
  logic             geo_fail;
  logic [25:0]      prod;
  logic [7:0]       ent_base;
  logic [7:0]       ent_off;
  logic [15:0]      seclen_cur;
  logic [15:0]      fin_len;
  logic [1:0]       fin_stat;

  assign accept       = item.valid && item.ready;
  assign item.ready   = (state == S_IDLE);
  assign fire_res     = (state == S_RES) && (!o_vld || result.ready);
  assign result.valid = o_vld;
  assign result.data  = o_data;

  assign trk_calc = ((heads > 8'd1) ? {1'b0, req.cylinder, 1'b0} : {2'b00, req.cylinder})
                    + {2'b00, req.head};
  assign geo_fail = (req.cylinder > max_cyl) || (req.head > heads) ||
                    (ext_ok && (trk_calc >= dsl_pkg::SIZE_TABLE_ENTRIES));
  assign prod     = {10'd0, tlen} * {16'd0, trk_calc};
  assign ent_base = dsl_pkg::TRK_ENTRIES + {n, 3'b000};
  assign seclen_cur = ext_ok ? {th_rdata, len_lo} : (dsl_pkg::SECTOR_BASE_LEN << code_lim);

  always_comb begin
    case (sub)
      SUB_ID:  ent_off = 8'd2;
      SUB_LLO: ent_off = 8'd6;
      SUB_LHI: ent_off = 8'd7;
      SUB_CYL: ent_off = 8'd0;
      default: ent_off = 8'd1;
    endcase
  end

  always_comb begin
    iss      = '0;
    dh_raddr = '0;
    th_raddr = '0;
    case (state)
      S_DSCAN: begin
        if (step != SCAN_END) begin
          iss = '{vld: 1'b1, kind: dsl_pkg::TAG_DH, step: step};
          dh_raddr = (step < EXT_LEN) ? {4'd0, step} : dsl_pkg::HDR_CYLS + {6'd0, step[1:0]};
        end
      end
      S_SUM: begin
        if (cnt != trk) begin
          iss = '{vld: 1'b1, kind: dsl_pkg::TAG_SUM, step: 4'd0};
          dh_raddr = dsl_pkg::HDR_SIZES + cnt;
        end
      end
      S_TSCAN: begin
        if (step != SCAN_END) begin
          iss = '{vld: 1'b1, kind: dsl_pkg::TAG_TH, step: step};
          th_raddr = (step < SIG_LEN) ? {4'd0, step} :
                     dsl_pkg::TRK_SIZE_CODE + {7'd0, step[0]};
        end
      end
      S_ENT: begin
        if (sub != SUB_DRAIN) begin
          iss = '{vld: 1'b1, kind: dsl_pkg::TAG_ENT, step: {1'b0, sub}};
          th_raddr = ent_base + ent_off;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fin_len  = req.request_len;
    fin_stat = dsl_pkg::STAT_OK;
    if (seclen != req.request_len) begin
      fin_stat = dsl_pkg::STAT_LEN_MISMATCH;
      if (seclen < fin_len) begin
        fin_len = seclen;
      end
    end
    if (fin_len > req.buffer_len) begin
      fin_len = req.buffer_len;
    end
    if (!id_match || !cyl_ok || !hd_ok) begin
      fin_res = '{status: dsl_pkg::STAT_NO_SECTOR, image_offset: 32'd0, transfer_len: 16'd0};
    end else begin
      fin_res = '{status: fin_stat,
                  image_offset: cur_off + dsl_pkg::HEADER_SPAN + {11'd0, offs},
                  transfer_len: fin_len};
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (item.data.operation == dsl_pkg::OP_LOAD_DISK)) begin
      dh_mem[item.data.byte_index] <= item.data.byte_value;
    end
    if (accept && (item.data.operation == dsl_pkg::OP_LOAD_TRACK)) begin
      th_mem[item.data.byte_index] <= item.data.byte_value;
    end
    dh_rdata <= dh_mem[dh_raddr];
    th_rdata <= th_mem[th_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      cnt     <= '0;
      n       <= '0;
      sub     <= SUB_ID;
      tag     <= '0;
      o_vld   <= 1'b0;
      cur_off <= '0;
    end else begin
      tag <= iss;
      if (fire_res) begin
        o_vld <= 1'b1;
      end else if (result.ready) begin
        o_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if ((item.data.operation == dsl_pkg::OP_FIND_TRACK) ||
                (item.data.operation == dsl_pkg::OP_FIND_SECTOR)) begin
              step  <= '0;
              state <= S_DSCAN;
            end else begin
              state <= S_RES;
            end
          end
        end
        S_DSCAN: begin
          if (step == SCAN_END) begin
            state <= S_DCHK;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_DCHK: begin
          if (geo_fail) begin
            state <= S_RES;
          end else if (ext_ok) begin
            cnt   <= '0;
            state <= S_SUM;
          end else begin
            state <= S_TRKOK;
          end
        end
        S_SUM: begin
          if (cnt == trk) begin
            state <= S_TRKOK;
          end else begin
            cnt <= cnt + 8'd1;
          end
        end
        S_TRKOK: begin
          cur_off <= acc;
          if (req.operation == dsl_pkg::OP_FIND_TRACK) begin
            state <= S_RES;
          end else begin
            step  <= '0;
            state <= S_TSCAN;
          end
        end
        S_TSCAN: begin
          if (step == SCAN_END) begin
            state <= S_TCHK;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_TCHK: begin
          if (!sig_ok || (count_raw == 8'd0)) begin
            state <= S_RES;
          end else begin
            n     <= '0;
            sub   <= SUB_ID;
            state <= S_ENT;
          end
        end
        S_ENT: begin
          case (sub)
            SUB_ID:  sub <= SUB_LLO;
            SUB_LLO: sub <= SUB_LHI;
            SUB_LHI: begin
              if (id_match) begin
                sub <= SUB_CYL;
              end else if ((n + 5'd1) < cnt_lim) begin
                n   <= n + 5'd1;
                sub <= SUB_ID;
              end else begin
                sub <= SUB_DRAIN;
              end
            end
            SUB_CYL: sub <= SUB_HD;
            SUB_HD:  sub <= SUB_DRAIN;
            default: state <= S_FIN;
          endcase
        end
        S_FIN: begin
          state <= S_RES;
        end
        S_RES: begin
          if (fire_res) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req    <= item.data;
      ext_ok <= 1'b1;
      sig_ok <= 1'b1;
      res    <= '{status: dsl_pkg::STAT_OK, image_offset: 32'd0, transfer_len: 16'd0};
    end
    if (tag.vld) begin
      case (tag.kind)
        dsl_pkg::TAG_DH: begin
          if (tag.step < EXT_LEN) begin
            if (dh_rdata != dsl_pkg::EXT_TAG[tag.step[2:0]]) begin
              ext_ok <= 1'b0;
            end
          end else begin
            case (tag.step[1:0])
              2'd0:    max_cyl    <= dh_rdata;
              2'd1:    heads      <= dh_rdata;
              2'd2:    tlen[7:0]  <= dh_rdata;
              default: tlen[15:8] <= dh_rdata;
            endcase
          end
        end
        dsl_pkg::TAG_SUM: begin
          acc <= acc + {15'd0, ({1'b0, dh_rdata} + 9'd1), 8'd0};
        end
        dsl_pkg::TAG_TH: begin
          if (tag.step < SIG_LEN) begin
            if (th_rdata != dsl_pkg::TRK_TAG[tag.step]) begin
              sig_ok <= 1'b0;
            end
          end else if (!tag.step[0]) begin
            code_raw <= th_rdata;
          end else begin
            count_raw <= th_rdata;
          end
        end
        default: begin
          case (tag.step[2:0])
            SUB_ID:  id_match <= (th_rdata == req.sector);
            SUB_LLO: len_lo   <= th_rdata;
            SUB_LHI: begin
              if (id_match) begin
                seclen <= seclen_cur;
              end else begin
                offs <= offs + {5'd0, seclen_cur};
              end
            end
            SUB_CYL: cyl_ok <= (th_rdata == req.cyl_expected);
            default: hd_ok  <= (th_rdata == req.head_expected);
          endcase
        end
      endcase
    end
    unique case (state)
      S_DCHK: begin
        trk <= trk_calc[7:0];
        if (geo_fail) begin
          res <= '{status: dsl_pkg::STAT_SEEK_FAIL, image_offset: 32'd0, transfer_len: 16'd0};
        end else if (ext_ok) begin
          acc <= dsl_pkg::HEADER_SPAN;
        end else begin
          acc <= {6'd0, prod} + dsl_pkg::HEADER_SPAN;
        end
      end
      S_TRKOK: begin
        res <= '{status: dsl_pkg::STAT_OK, image_offset: acc, transfer_len: 16'd0};
      end
      S_TCHK: begin
        cnt_lim  <= (count_raw > {3'd0, dsl_pkg::MAX_SECTOR_ENTRIES}) ?
                    dsl_pkg::MAX_SECTOR_ENTRIES : count_raw[4:0];
        code_lim <= (code_raw > {4'd0, dsl_pkg::MAX_SIZE_CODE}) ?
                    dsl_pkg::MAX_SIZE_CODE : code_raw[3:0];
        offs     <= '0;
        if (!sig_ok || (count_raw == 8'd0)) begin
          res <= '{status: dsl_pkg::STAT_NO_SECTOR, image_offset: 32'd0, transfer_len: 16'd0};
        end
      end
      S_FIN: begin
        res <= fin_res;
      end
      S_RES: begin
        if (fire_res) begin
          o_data <= res;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### design/dsl_checker.sv
// ----------------------------------------------------------------------------
// dsl_checker - port-level checks of the disk image sector locator
// Watches the item and result channels; bound to the top level.
// ----------------------------------------------------------------------------
module dsl_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [1:0]  result_status,
  input logic [31:0] result_offset,
  input logic [15:0] result_len
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("item taken while previous item still in work");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(result_status) && $stable(result_offset) &&
       $stable(result_len)))
    else $error("stalled result changed or dropped");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ((result_status == dsl_pkg::STAT_SEEK_FAIL) ||
                      (result_status == dsl_pkg::STAT_NO_SECTOR))) |->
      ((result_offset == 32'd0) && (result_len == 16'd0)))
    else $error("failure result carries offset or length");

  a_offset_past_header: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_offset != 32'd0)) |-> (result_offset >= 32'd256))
    else $error("offset points into the image header");

endmodule

bind disk_image_sector_locator dsl_checker u_dsl_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_status (result.data.status),
  .result_offset (result.data.image_offset),
  .result_len    (result.data.transfer_len)
);
